/* hw/rtl/pcbp_pkg.sv */
`timescale 1ns / 1ps

package pcbp_pkg;

    localparam int BYTE_BITS = 8;
    localparam int PEND_W    = BYTE_BITS - 1;
    localparam int PCNT_W    = 3;
    localparam int TOTAL_W   = 32;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    // Fill value for the unused tail of the last byte
    localparam logic PAD_BIT = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } opcode_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic        byte_valid;
        logic [31:0] total_bits;
        logic        last;
    } res_t;

endpackage

/* hw/rtl/pcbp_table.sv */
`timescale 1ns / 1ps

module pcbp_table
    import pcbp_pkg::*;
#(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
    parameter int CODE_W       = MAX_CODE_LEN_DEF,
    parameter int LEN_W        = 6,
    localparam int ADDR_W      = $clog2(SYMBOL_COUNT)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [CODE_W-1:0] wr_code,
    input  logic [LEN_W-1:0]  wr_len,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [CODE_W-1:0] rd_code,
    output logic [LEN_W-1:0]  rd_len
);

    logic [CODE_W+LEN_W-1:0] table_reg [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] valid_reg;
    logic [CODE_W+LEN_W-1:0] rd_data_reg;
    logic                    rd_hit_reg;

    // Entry storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_reg[wr_addr] <= {wr_code, wr_len};
        end
        if (rd_en)
        begin
            rd_data_reg <= table_reg[rd_addr];
        end
    end

    // Valid bits: an entry never written reads as length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_code = rd_data_reg[CODE_W+LEN_W-1:LEN_W];
    assign rd_len  = rd_hit_reg ? rd_data_reg[LEN_W-1:0] : '0;

endmodule

/* hw/rtl/prefix_code_bit_packer_top.sv */
`timescale 1ns / 1ps

// A taken beat passes the stage 1 register, then the burst register offers its bytes.
// Throughput: one item per cycle when it yields at most one byte and the receiver
// does not stall; otherwise one output byte per unstalled cycle, up to ceil(MAX_CODE_LEN/8) bytes per encode.
// Reset: asynchronous, active low; clears table valid bits, pending bits and
// bit total, and empties the pipeline. No clearing pass is needed.

module prefix_code_bit_packer_top
    import pcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam int CODE_W  = MAX_CODE_LEN;
    localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
    localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
    localparam int ACC_W   = MAX_CODE_LEN + PEND_W;
    localparam int CNT_W   = $clog2(ACC_W + 1);
    localparam int MAX_OUT = ACC_W / BYTE_BITS;
    localparam int RW      = $clog2(MAX_OUT + 1);

    // ------------------------------------------------------------------
    // Input side: table write for loads, table read for encodes
    // ------------------------------------------------------------------
    logic              cmd_accept;
    logic              sym_in_range;
    logic [LEN_W-1:0]  ld_len;
    logic [63:0]       code_wide;
    logic [CODE_W-1:0] ld_code;
    logic              tbl_wr_en;
    logic              tbl_rd_en;
    logic [CODE_W-1:0] tbl_code;
    logic [LEN_W-1:0]  tbl_len;

    assign cmd_accept   = cmd_valid && !cmd_stall;
    assign sym_in_range = int'(cmd.symbol) < SYMBOL_COUNT;

    // Clamp the length, drop code bits above it; bits past the 32-bit word are zero
    assign ld_len    = (int'(cmd.code_length) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN)
                                                              : LEN_W'(cmd.code_length);
    assign code_wide = {32'b0, cmd.code_bits};
    assign ld_code   = code_wide[CODE_W-1:0] & ~({CODE_W{1'b1}} << ld_len);

    assign tbl_wr_en = cmd_accept && (cmd.opcode == OP_LOAD) && sym_in_range;
    assign tbl_rd_en = cmd_accept && (cmd.opcode == OP_ENCODE) && sym_in_range;

    pcbp_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .CODE_W       (CODE_W),
        .LEN_W        (LEN_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (cmd.symbol[ADDR_W-1:0]),
        .wr_code (ld_code),
        .wr_len  (ld_len),
        .rd_en   (tbl_rd_en),
        .rd_addr (cmd.symbol[ADDR_W-1:0]),
        .rd_code (tbl_code),
        .rd_len  (tbl_len)
    );

    // ------------------------------------------------------------------
    // Stage 1 register: opcode and range flag; the table read lands alongside
    // ------------------------------------------------------------------
    logic    s1_valid_reg;
    opcode_t s1_op_reg;
    logic    s1_hit_reg;
    logic    s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            s1_op_reg  <= cmd.opcode;
            s1_hit_reg <= sym_in_range;
        end
    end

    // ------------------------------------------------------------------
    // Packing: merge the code below the pending bits, cut out whole bytes
    // ------------------------------------------------------------------
    logic [PEND_W-1:0]  pend_bits_reg;
    logic [PCNT_W-1:0]  pend_cnt_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [LEN_W-1:0]     enc_len;
    logic [ACC_W-1:0]     acc;
    logic [CNT_W-1:0]     cnt;
    logic [ACC_W-1:0]     aligned;
    logic [RW-1:0]        nb;
    logic [PEND_W-1:0]    pend_bits_next;
    logic [TOTAL_W:0]     total_sum;
    logic [TOTAL_W-1:0]   total_sat;
    logic [PCNT_W:0]      pad_shift;
    logic [BYTE_BITS-1:0] padded;
    logic                 needs_burst;

    logic [BYTE_BITS-1:0] ld_bytes [MAX_OUT];
    logic [RW-1:0]        ld_rem;
    logic [TOTAL_W-1:0]   ld_total;
    logic                 ld_last;
    logic                 ld_bv;

    always_comb
    begin
        enc_len   = s1_hit_reg ? tbl_len : '0;
        acc       = (ACC_W'(pend_bits_reg) << enc_len) | ACC_W'(tbl_code);
        cnt       = CNT_W'(pend_cnt_reg) + CNT_W'(enc_len);
        // Left-align so that byte k sits at a fixed slice
        aligned   = acc << (CNT_W'(ACC_W) - cnt);
        nb        = RW'(cnt / BYTE_BITS);
        pend_bits_next = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << cnt[PCNT_W-1:0]);

        total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(enc_len);
        total_sat = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

        // Flush: shift pending bits to the top, fill the tail with the pad bit
        pad_shift = (PCNT_W + 1)'(BYTE_BITS) - {1'b0, pend_cnt_reg};
        padded    = (BYTE_BITS'(pend_bits_reg) << pad_shift)
                  | ({BYTE_BITS{PAD_BIT}} & ~({BYTE_BITS{1'b1}} << pad_shift));

        for (int k = 0; k < MAX_OUT; k++)
        begin
            ld_bytes[k] = aligned[ACC_W-1-BYTE_BITS*k -: BYTE_BITS];
        end
        ld_rem      = nb;
        ld_total    = total_sat;
        ld_last     = 1'b0;
        ld_bv       = 1'b1;
        needs_burst = 1'b0;

        unique case (s1_op_reg)
            OP_ENCODE:
            begin
                needs_burst = (nb != '0);
            end
            OP_FLUSH:
            begin
                needs_burst = 1'b1;
                ld_rem      = RW'(1);
                ld_total    = total_reg;
                ld_last     = 1'b1;
                ld_bv       = (pend_cnt_reg != '0);
                ld_bytes[0] = (pend_cnt_reg != '0) ? padded : '0;
            end
            default:
            begin
                needs_burst = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Burst register: holds the bytes of one item and drains one per beat
    // ------------------------------------------------------------------
    logic [BYTE_BITS-1:0] burst_bytes_reg [MAX_OUT];
    logic [RW-1:0]        burst_rem_reg;
    logic [TOTAL_W-1:0]   burst_total_reg;
    logic                 burst_last_reg;
    logic                 burst_bv_reg;
    logic                 res_accept;
    logic                 burst_free;
    logic                 burst_load;

    assign res_valid  = (burst_rem_reg != '0);
    assign res_accept = res_valid && !res_stall;
    // Free now, or the final byte leaves on this edge
    assign burst_free = (burst_rem_reg == '0) || ((burst_rem_reg == RW'(1)) && !res_stall);

    // Items that yield no byte pass even while a burst drains
    assign s1_adv     = s1_valid_reg && (!needs_burst || burst_free);
    assign burst_load = s1_adv && needs_burst;
    assign cmd_stall  = s1_valid_reg && !s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_rem_reg <= '0;
        end
        else if (burst_load)
        begin
            burst_rem_reg <= ld_rem;
        end
        else if (res_accept)
        begin
            burst_rem_reg <= burst_rem_reg - RW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_load)
        begin
            burst_bytes_reg <= ld_bytes;
            burst_total_reg <= ld_total;
            burst_last_reg  <= ld_last;
            burst_bv_reg    <= ld_bv;
        end
        else if (res_accept)
        begin
            // Advance the next byte to the head
            for (int k = 0; k < MAX_OUT - 1; k++)
            begin
                burst_bytes_reg[k] <= burst_bytes_reg[k+1];
            end
        end
    end

    assign res.byte_value = burst_bytes_reg[0];
    assign res.byte_valid = burst_bv_reg;
    assign res.total_bits = burst_total_reg;
    assign res.last       = burst_last_reg;

    // ------------------------------------------------------------------
    // Accumulator state: update as the item leaves stage 1
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            total_reg     <= '0;
        end
        else if (s1_adv)
        begin
            unique case (s1_op_reg)
                OP_ENCODE:
                begin
                    // Unloaded or out-of-range symbols leave everything as is
                    if (enc_len != '0)
                    begin
                        pend_bits_reg <= pend_bits_next;
                        pend_cnt_reg  <= cnt[PCNT_W-1:0];
                        total_reg     <= total_sat;
                    end
                end
                OP_FLUSH:
                begin
                    pend_bits_reg <= '0;
                    pend_cnt_reg  <= '0;
                    total_reg     <= '0;
                end
                default:
                begin
                    pend_cnt_reg <= pend_cnt_reg;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // With a zero pending count, the pending bits must all be clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_cnt_reg == '0) |-> (pend_bits_reg == '0))
        else $error("pending bits set with zero pending count");

    // A flush leaves an empty accumulator behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_op_reg == OP_FLUSH)) |=> ((pend_cnt_reg == '0) && (total_reg == '0)))
        else $error("accumulator not cleared after flush");

    // The flush beat is always the only beat of its burst
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |-> (burst_rem_reg == RW'(1)))
        else $error("last flag on a beat that is not final");

    // The burst never claims more bytes than it can hold
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(burst_rem_reg) <= MAX_OUT)
        else $error("burst count beyond capacity");
`endif

endmodule

/* bench/tb_prefix_code_bit_packer_top.sv */
`timescale 1ns / 1ps

module tb_prefix_code_bit_packer_top;

    import pcbp_pkg::*;

    // Opcode 3 has no meaning in the block; it must be dropped without a result
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam int MAX_LEN      = MAX_CODE_LEN_DEF;
    localparam int SYM_COUNT    = SYMBOL_COUNT_DEF;
    localparam int RAND_ITEMS   = 340;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    localparam res_t NO_RES = '0;

    // One row of the directed table. Rows with 'typed' set carry their expected
    // results inline: n_typed copies of typed_res. Other rows use the packer model.
    typedef struct packed {
        cmd_t       c;
        logic       typed;
        logic [2:0] n_typed;
        res_t       typed_res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;

    prefix_code_bit_packer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Packer model state: code table plus the bit accumulator
    logic [31:0] tbl_code [SYM_COUNT];
    logic [5:0]  tbl_len  [SYM_COUNT];
    logic [6:0]  pend_bits;
    logic [2:0]  pend_cnt;
    logic [31:0] bit_count;

    // Results of the latest modeled beat
    res_t model_out [4];
    int   model_n;

    // Results still owed by the block, oldest first
    res_t owed_bytes [$];

    dir_row_t   dir_rows [$];
    logic [7:0] live_syms [$];

    int   errors = 0;
    int   results_seen = 0;
    int   flushes_seen = 0;
    int   beats_sent;
    int   burst_left;
    int   rand_counted;
    int   cycle_count = 0;
    logic hold_off_req;
    logic hold_off_done;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Append helpers for the queues
    function automatic void add_owed(input res_t r);
        owed_bytes = {owed_bytes, r};
    endfunction

    function automatic void add_live(input logic [7:0] sym);
        live_syms = {live_syms, sym};
    endfunction

    function automatic void add_row(input dir_row_t d);
        dir_rows = {dir_rows, d};
    endfunction

    // ------------------------------------------------------------------
    // Packer model: advance the state by one accepted beat and leave the
    // results it causes in model_out[0 .. model_n-1].
    // ------------------------------------------------------------------
    task automatic pack_model(input cmd_t c);
        logic [63:0] acc;
        logic [32:0] sum;
        res_t        r;
        int          len;
        int          cnt;
        model_n = 0;
        case (c.opcode)
            OP_LOAD:
            begin
                if (c.symbol < SYM_COUNT)
                begin
                    // clamp overlong lengths, drop code bits above the length
                    len = (c.code_length > MAX_LEN) ? MAX_LEN : int'(c.code_length);
                    tbl_len[c.symbol]  = 6'(len);
                    tbl_code[c.symbol] = 32'({32'd0, c.code_bits} & ((64'd1 << len) - 64'd1));
                end
            end
            OP_ENCODE:
            begin
                len = (c.symbol < SYM_COUNT) ? int'(tbl_len[c.symbol]) : 0;
                if (len != 0)
                begin
                    acc = ({57'd0, pend_bits} << len) | {32'd0, tbl_code[c.symbol]};
                    cnt = int'(pend_cnt) + len;
                    sum = {1'b0, bit_count} + 33'(len);
                    bit_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    // emit every byte that became complete, oldest bits first
                    while (cnt >= BYTE_BITS)
                    begin
                        cnt = cnt - BYTE_BITS;
                        r.byte_value = 8'(acc >> cnt);
                        r.byte_valid = 1'b1;
                        r.total_bits = bit_count;
                        r.last       = 1'b0;
                        model_out[model_n] = r;
                        model_n = model_n + 1;
                    end
                    pend_bits = 7'(acc & ((64'd1 << cnt) - 64'd1));
                    pend_cnt  = 3'(cnt);
                end
            end
            OP_FLUSH:
            begin
                cnt = int'(pend_cnt);
                r.byte_value = 8'h00;
                if (cnt > 0)
                begin
                    r.byte_value = 8'({1'b0, pend_bits} << (BYTE_BITS - cnt));
                    if (PAD_BIT)
                        r.byte_value = r.byte_value | 8'((9'd1 << (BYTE_BITS - cnt)) - 9'd1);
                end
                r.byte_valid = (cnt > 0);
                r.total_bits = bit_count;
                r.last       = 1'b1;
                model_out[0] = r;
                model_n   = 1;
                pend_bits = '0;
                pend_cnt  = '0;
                bit_count = '0;
            end
            default:
            begin
                // unused opcode: no state change, no result
            end
        endcase
    endtask

    function automatic dir_row_t row(logic [1:0] op, logic [7:0] sym, logic [31:0] code,
                                     logic [5:0] len, logic typed, int n, res_t r);
        dir_row_t d;
        d.c.opcode      = opcode_t'(op);
        d.c.symbol      = sym;
        d.c.code_bits   = code;
        d.c.code_length = len;
        d.typed         = typed;
        d.n_typed       = 3'(n);
        d.typed_res     = r;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Sender: present one beat and hold it until the block takes it.
    // Beats come in bursts of random length; a burst may start after a
    // random gap, or right away so that long gap-free stretches occur.
    // ------------------------------------------------------------------
    task automatic send_beat(input cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        beats_sent = beats_sent + 1;
    endtask

    // Model an accepted beat and queue what the block owes for it
    task automatic book_beat(input cmd_t c);
        int k;
        pack_model(c);
        if (c.opcode == OP_LOAD && c.code_length != 0)
            add_live(c.symbol);
        for (k = 0; k < model_n; k++)
            add_owed(model_out[k]);
    endtask

    // Draw one random beat. Most of the traffic is well-formed: loads of
    // live codes, encodes of loaded symbols and regular flushes. The rest is
    // noise: encodes of possibly unloaded symbols and the unused opcode.
    task automatic draw_beat(output cmd_t c, output logic counts);
        int pick;
        int q;
        pick = $urandom_range(0, 99);
        c.symbol      = 8'($urandom);
        c.code_bits   = $urandom;
        c.code_length = 6'($urandom);
        if (pick < 12)
        begin
            c.opcode = OP_LOAD;
            if (live_syms.size() > 0 && $urandom_range(0, 1) == 1)
                c.symbol = live_syms[$urandom_range(0, live_syms.size() - 1)];
            q = $urandom_range(0, 99);
            // mostly short codes, some long ones, a few overlong and unloads
            if (q < 60)
                c.code_length = 6'($urandom_range(1, 10));
            else if (q < 82)
                c.code_length = 6'($urandom_range(11, 32));
            else if (q < 94)
                c.code_length = 6'($urandom_range(33, 63));
            else
                c.code_length = 6'd0;
        end
        else if (pick < 80)
        begin
            c.opcode = OP_ENCODE;
            if (live_syms.size() > 0 && $urandom_range(0, 9) != 0)
                c.symbol = live_syms[$urandom_range(0, live_syms.size() - 1)];
        end
        else if (pick < 92)
            c.opcode = OP_FLUSH;
        else if (pick < 96)
            c.opcode = OP_ENCODE;
        else
            c.opcode = opcode_t'(OP_NONE);
        counts = !(c.opcode == opcode_t'(OP_NONE)
                   || (c.opcode == OP_ENCODE && tbl_len[c.symbol] == 0));
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random traffic, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        int   i;
        int   k;
        cmd_t c;
        logic counts;

        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        hold_off_req <= 1'b0;
        beats_sent   = 0;
        burst_left   = 0;
        rand_counted = 0;
        pend_bits    = '0;
        pend_cnt     = '0;
        bit_count    = '0;
        for (i = 0; i < SYM_COUNT; i++)
        begin
            tbl_code[i] = '0;
            tbl_len[i]  = '0;
        end

        // flush straight after reset: nothing pending, count zero
        add_row(row(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b1, 1,
                    '{8'h00, 1'b0, 32'd0, 1'b1}));
        // encode of a symbol that was never loaded
        add_row(row(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b1, 0, NO_RES));
        // unused opcode with every other field bit high
        add_row(row(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b1, 0, NO_RES));
        // overlong length clamps to the maximum code length
        add_row(row(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b1, 0, NO_RES));
        add_row(row(OP_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b1, 4,
                    '{8'hFF, 1'b1, 32'd32, 1'b0}));
        // byte-aligned tail: empty flush still reports the count
        add_row(row(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b1, 1,
                    '{8'h00, 1'b0, 32'd32, 1'b1}));
        add_row(row(OP_LOAD, 8'h00, 32'h0000_0000, 6'd1, 1'b0, 0, NO_RES));
        // code bits above the length get dropped
        add_row(row(OP_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd3, 1'b0, 0, NO_RES));
        add_row(row(OP_LOAD, 8'h80, 32'hAAAA_AAAA, 6'd32, 1'b0, 0, NO_RES));
        // zero-length load leaves the entry unloaded
        add_row(row(OP_LOAD, 8'h7F, 32'h5555_5555, 6'd0, 1'b0, 0, NO_RES));
        add_row(row(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0, 0, NO_RES));
        add_row(row(OP_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0, 0, NO_RES));
        add_row(row(OP_ENCODE, 8'h7F, 32'h0, 6'd0, 1'b0, 0, NO_RES));
        add_row(row(OP_ENCODE, 8'h80, 32'h0, 6'd0, 1'b0, 0, NO_RES));
        add_row(row(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0, 0, NO_RES));
        // build up seven pending bits, then append a full-length code
        add_row(row(OP_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0, 0, NO_RES));
        add_row(row(OP_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0, 0, NO_RES));
        add_row(row(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0, 0, NO_RES));
        add_row(row(OP_LOAD, 8'h02, 32'h1234_5678, 6'd33, 1'b0, 0, NO_RES));
        add_row(row(OP_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0, 0, NO_RES));
        add_row(row(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0, 0, NO_RES));
        // seven pending ones padded on flush
        add_row(row(OP_LOAD, 8'h00, 32'h0000_007F, 6'd7, 1'b0, 0, NO_RES));
        add_row(row(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b0, 0, NO_RES));
        add_row(row(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0, 0, NO_RES));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: typed rows queue their inline results, the model
        // still tracks every row so that later rows predict correctly
        for (i = 0; i < dir_rows.size(); i++)
        begin
            send_beat(dir_rows[i].c);
            if (dir_rows[i].typed)
            begin
                pack_model(dir_rows[i].c);
                if (dir_rows[i].c.opcode == OP_LOAD && dir_rows[i].c.code_length != 0)
                    add_live(dir_rows[i].c.symbol);
                for (k = 0; k < dir_rows[i].n_typed; k++)
                    add_owed(dir_rows[i].typed_res);
            end
            else
                book_beat(dir_rows[i].c);
        end

        // Random part: count only beats the block acts on
        while (rand_counted < RAND_ITEMS)
        begin
            draw_beat(c, counts);
            send_beat(c);
            book_beat(c);
            if (counts)
                rand_counted = rand_counted + 1;
            // ask the receiver for its long hold-off once, mid-run
            if (rand_counted == HOLD_AT && !hold_off_req)
                hold_off_req <= 1'b1;
        end
        cmd_valid <= 1'b0;

        // Drain: wait for every owed result, then watch for strays
        while (owed_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d beats (%0d directed, %0d random acted on): %0d results.",
                 beats_sent, dir_rows.size(), rand_counted, results_seen);
        $display("%0d flushes, receiver hold-off %0s; %0d mismatches.",
                 flushes_seen, hold_off_done ? "done" : "missed", errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver stall: rotate through four patterns in turn (none, coin toss,
    // fixed periodic, light random). Once asked, hold off for a long
    // stretch so the block fills and stalls its input.
    // ------------------------------------------------------------------
    initial
    begin
        int cyc;
        int held;
        res_stall <= 1'b0;
        hold_off_done = 1'b0;
        cyc = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                res_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            else
            begin
                case ((cyc / 64) % 4)
                    0:       res_stall <= 1'b0;
                    1:       res_stall <= ($urandom_range(0, 1) == 1);
                    2:       res_stall <= ((cyc % 5) < 3);
                    default: res_stall <= ($urandom_range(0, 4) == 0);
                endcase
                cyc = cyc + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: compare each accepted result beat with the oldest owed
    // one, field by field. Report the first few, count the rest.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        res_t want;
        logic bad;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen = results_seen + 1;
            if (res.last)
                flushes_seen = flushes_seen + 1;
            if (owed_bytes.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= REPORT_MAX)
                    $display("[%0t] unexpected result: byte=%02h valid=%b total=%0d last=%b",
                             $time, res.byte_value, res.byte_valid, res.total_bits, res.last);
            end
            else
            begin
                want = owed_bytes.pop_front();
                bad = (res.byte_value !== want.byte_value)
                      || (res.byte_valid !== want.byte_valid)
                      || (res.total_bits !== want.total_bits)
                      || (res.last !== want.last);
                if (bad)
                begin
                    errors = errors + 1;
                    if (errors <= REPORT_MAX)
                    begin
                        $display("[%0t] mismatch: expected byte=%02h valid=%b total=%0d last=%b",
                                 $time, want.byte_value, want.byte_valid, want.total_bits,
                                 want.last);
                        $display("            got      byte=%02h valid=%b total=%0d last=%b",
                                 res.byte_value, res.byte_valid, res.total_bits, res.last);
                    end
                end
            end
        end
    end

    // Cycle counter: end the run if it never drains
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still owed",
                     cycle_count, owed_bytes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

/* files.f */
hw/rtl/pcbp_pkg.sv
hw/rtl/pcbp_table.sv
hw/rtl/prefix_code_bit_packer_top.sv
bench/tb_prefix_code_bit_packer_top.sv
